@@ hw/rtl/y2r_pkg.sv @@
package y2r_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_OUT_WIDTH  = 2'd2,
    REG_OUT_HEIGHT = 2'd3
  } cfg_idx_t;

  localparam logic [11:0] SRC_WIDTH_RST  = 12'd1280;
  localparam logic [11:0] SRC_HEIGHT_RST = 12'd720;
  localparam logic [11:0] OUT_WIDTH_RST  = 12'd368;
  localparam logic [11:0] OUT_HEIGHT_RST = 12'd207;

  // Queue between classifier and converter
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // BT.601 full-range coefficients, scaled by 256
  localparam logic signed [16:0] K_RV = 17'sd359;
  localparam logic signed [16:0] K_GU = 17'sd88;
  localparam logic signed [16:0] K_GV = 17'sd183;
  localparam logic signed [16:0] K_BU = 17'sd454;
  localparam logic signed [9:0]  CHROMA_OFS = 10'sd128;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } in_t;

  typedef struct packed {
    logic [15:0] pixel_be;
    logic        row_end;
    logic        frame_end;
  } out_t;

  // One picked pixel on its way to the converter
  typedef struct packed {
    in_t  pix;
    logic row_end;
    logic frame_end;
  } job_t;

endpackage

@@ hw/rtl/yuv420_to_rgb565_scaler.sv @@
// Nearest-neighbour downscaler with full-range BT.601 YUV to big-endian
// RGB565 conversion. Push one source pixel (luma plus its co-sited chroma)
// per transfer in raster order; one result comes out for every source pixel
// that falls on the output grid, flagged with row_end and frame_end. The block
// sustains one source pixel per clock while full is low: the front classifier
// decides on a pixel in the cycle it is transferred, using its column and row
// counters and two accumulators (one add and compare each), and the converter
// behind the four-entry queue is a two-stage pipeline (constant multiplies,
// then add, clamp and pack into the output register), so a picked pixel goes
// through a queue entry, the stage-one registers and the output register to
// the result side. Full is high while a configuration write is offered, for
// one cycle after reset and after every configuration write while the
// counters reload from the new sizes, and whenever the queue is full.
// Every configuration write restarts the frame; write only while the block is
// idle. Output sizes above the source sizes are taken as the source sizes.
module yuv420_to_rgb565_scaler #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  // source pixel side
  input  logic              push,
  output logic              full,
  input  y2r_pkg::in_t      source,
  // result side
  output logic              empty,
  input  logic              pop,
  output y2r_pkg::out_t     result,
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  y2r_pkg::cfg_idx_t cfg_index,
  input  logic [11:0]       cfg_data
);

  logic          q_push, q_full, q_pop, q_empty;
  y2r_pkg::job_t q_in, q_out;

  // configuration is taken in any cycle
  assign cfg_ready = 1'b1;

  // classify: advance counters, pick pixels on the output grid
  y2r_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .source   (source),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_in)
  );

  // decouple the classifier from the converter
  y2r_fifo u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_data(q_in),
    .full   (q_full),
    .rd     (q_pop),
    .rd_data(q_out),
    .empty  (q_empty)
  );

  // convert and hold results until popped
  y2r_back u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_job  (q_out),
    .q_pop  (q_pop),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

@@ hw/rtl/y2r_front.sv @@
module y2r_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  y2r_pkg::in_t      source,
  input  logic              cfg_valid,
  input  y2r_pkg::cfg_idx_t cfg_index,
  input  logic [11:0]       cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output y2r_pkg::job_t     q_job
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int CAW = 2 * CW + 1;
  localparam int RAW = 2 * RW + 1;

  logic [11:0] src_width, src_height, out_width, out_height;
  logic        restart;

  logic [CW-1:0] sw, ow, scol, ocol;
  logic [RW-1:0] sh, oh, srow, orow;
  logic signed [CAW-1:0] cacc, cacc_next;
  logic signed [RAW-1:0] racc, racc_next;

  logic col_pick, row_pick, accept, line_end, frame_last, last_col;

  always_comb begin
    if (src_width == 12'd0) begin
      sw = CW'(1);
    end else if (src_width > MAX_WIDTH) begin
      sw = CW'(MAX_WIDTH);
    end else begin
      sw = CW'(src_width);
    end
    if (src_height == 12'd0) begin
      sh = RW'(1);
    end else if (src_height > MAX_HEIGHT) begin
      sh = RW'(MAX_HEIGHT);
    end else begin
      sh = RW'(src_height);
    end
    ow = (out_width > sw) ? sw : CW'(out_width);
    oh = (out_height > sh) ? sh : RW'(out_height);
  end

  assign col_pick = (cacc >= 0) && (cacc < $signed(CAW'(ow))) && (ocol < ow);
  assign row_pick = (racc >= 0) && (racc < $signed(RAW'(oh))) && (orow < oh);

  assign full       = q_full || restart || cfg_valid;
  assign accept     = push && !full;
  assign line_end   = (scol + CW'(1)) >= sw;
  assign frame_last = (srow + RW'(1)) >= sh;
  assign last_col   = (ocol + CW'(1)) == ow;

  assign cacc_next = cacc - $signed(CAW'(ow)) + (col_pick ? $signed(CAW'(sw)) : CAW'(0));
  assign racc_next = racc - $signed(RAW'(oh)) + (row_pick ? $signed(RAW'(sh)) : RAW'(0));

  assign q_push          = accept && col_pick && row_pick;
  assign q_job.pix       = source;
  assign q_job.row_end   = last_col;
  assign q_job.frame_end = last_col && ((orow + RW'(1)) == oh);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= y2r_pkg::SRC_WIDTH_RST;
      src_height <= y2r_pkg::SRC_HEIGHT_RST;
      out_width  <= y2r_pkg::OUT_WIDTH_RST;
      out_height <= y2r_pkg::OUT_HEIGHT_RST;
      restart    <= 1'b1;
      scol       <= '0;
      ocol       <= '0;
      srow       <= '0;
      orow       <= '0;
      cacc       <= '0;
      racc       <= '0;
    end else begin
      restart <= 1'b0;
      if (cfg_valid) begin
        unique case (cfg_index)
          y2r_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data;
          y2r_pkg::REG_SRC_HEIGHT: src_height <= cfg_data;
          y2r_pkg::REG_OUT_WIDTH:  out_width  <= cfg_data;
          y2r_pkg::REG_OUT_HEIGHT: out_height <= cfg_data;
        endcase
        restart <= 1'b1;
      end
      if (restart) begin
        // reload from the registers as they now stand
        scol <= '0;
        ocol <= '0;
        srow <= '0;
        orow <= '0;
        cacc <= $signed(CAW'(sw >> 1));
        racc <= $signed(RAW'(sh >> 1));
      end else if (accept) begin
        if (!line_end) begin
          scol <= scol + CW'(1);
          cacc <= cacc_next;
          if (col_pick) begin
            ocol <= ocol + CW'(1);
          end
        end else begin
          scol <= '0;
          ocol <= '0;
          cacc <= $signed(CAW'(sw >> 1));
          if (frame_last) begin
            srow <= '0;
            orow <= '0;
            racc <= $signed(RAW'(sh >> 1));
          end else begin
            srow <= srow + RW'(1);
            racc <= racc_next;
            if (row_pick) begin
              orow <= orow + RW'(1);
            end
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/y2r_fifo.sv @@
module y2r_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  y2r_pkg::job_t wr_data,
  output logic          full,
  input  logic          rd,
  output y2r_pkg::job_t rd_data,
  output logic          empty
);

  y2r_pkg::job_t entries [y2r_pkg::Q_DEPTH];

  logic [y2r_pkg::Q_AW-1:0] wr_ptr, rd_ptr;
  logic [y2r_pkg::Q_AW:0]   count;
  logic                     do_wr, do_rd;

  assign full    = count == (y2r_pkg::Q_AW + 1)'(y2r_pkg::Q_DEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (y2r_pkg::Q_AW + 1)'(do_wr) - (y2r_pkg::Q_AW + 1)'(do_rd);
    end
  end

endmodule

@@ hw/rtl/y2r_back.sv @@
module y2r_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  y2r_pkg::job_t q_job,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output y2r_pkg::out_t result
);

  function automatic logic [7:0] clamp8(input logic signed [10:0] x);
    logic [7:0] c;
    if (x < 0) begin
      c = 8'd0;
    end else if (x > 11'sd255) begin
      c = 8'd255;
    end else begin
      c = x[7:0];
    end
    return c;
  endfunction

  logic                  s1_v, s2_v;
  logic                  s1_ready, s2_ready;
  logic [7:0]            s1_y;
  logic signed [16:0]    s1_r, s1_g, s1_b;
  logic                  s1_row_end, s1_frame_end;
  logic signed [9:0]     u, v;
  logic signed [10:0]    rs, gs, bs;
  logic [7:0]            r8, g8, b8;
  logic [15:0]           px;

  assign s2_ready = !s2_v || pop;
  assign s1_ready = !s1_v || s2_ready;
  assign q_pop    = !q_empty && s1_ready;
  assign empty    = !s2_v;

  assign u = $signed({2'b00, q_job.pix.chroma_blue}) - y2r_pkg::CHROMA_OFS;
  assign v = $signed({2'b00, q_job.pix.chroma_red}) - y2r_pkg::CHROMA_OFS;

  // stage 2: add floored terms, clamp, pack
  assign rs = $signed({3'b000, s1_y}) + 11'(s1_r >>> 8);
  assign gs = $signed({3'b000, s1_y}) - 11'(s1_g >>> 8);
  assign bs = $signed({3'b000, s1_y}) + 11'(s1_b >>> 8);
  assign r8 = clamp8(rs);
  assign g8 = clamp8(gs);
  assign b8 = clamp8(bs);
  assign px = {r8[7:3], g8[7:2], b8[7:3]};

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_y         <= q_job.pix.luma;
      s1_r         <= 17'(v * y2r_pkg::K_RV);
      s1_g         <= 17'(u * y2r_pkg::K_GU) + 17'(v * y2r_pkg::K_GV);
      s1_b         <= 17'(u * y2r_pkg::K_BU);
      s1_row_end   <= q_job.row_end;
      s1_frame_end <= q_job.frame_end;
    end
    if (s1_v && s2_ready) begin
      result.pixel_be  <= {px[7:0], px[15:8]};
      result.row_end   <= s1_row_end;
      result.frame_end <= s1_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v <= q_pop;
      end
      if (s2_ready) begin
        s2_v <= s1_v;
      end
    end
  end

endmodule

@@ hw/rtl/y2r_checker.sv @@
module y2r_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input y2r_pkg::out_t     result,
  input logic              cfg_valid,
  input logic              cfg_ready
);

  // a waiting result holds until transferred
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while stalled");

  // frame end is always also a row end
  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.frame_end) |-> result.row_end)
    else $error("frame_end without row_end");

  // nothing waits and nothing is taken right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> (empty && full))
    else $error("block not idle after reset");

  // a configuration write holds off source transfers while counters reload
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> full)
    else $error("source taken during restart");

endmodule

bind yuv420_to_rgb565_scaler y2r_checker u_checker (.*);

@@ bench/yuv420_to_rgb565_scaler_test.sv @@
module yuv420_to_rgb565_scaler_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Sizes above these limits are clipped by the block.
  localparam int MAX_W = 2048;
  localparam int MAX_H = 2048;
  // Cycles to let the converter pipeline settle once the result queue runs dry.
  localparam int SETTLE_CYCLES = 8;
  // Cycles without any transfer before the run is declared hung.
  localparam int HANG_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 600;

  typedef enum logic [0:0] {
    ROW_WRITE = 1'b0,
    ROW_PIXEL = 1'b1
  } row_kind_t;

  // One line of the directed script: a register write or a source pixel. Where
  // typed is set, want is the result read straight off the conversion rules.
  typedef struct packed {
    row_kind_t         kind;
    y2r_pkg::cfg_idx_t idx;
    logic [11:0]       data;
    y2r_pkg::in_t      px;
    logic              typed;
    y2r_pkg::out_t     want;
  } script_row_t;

  localparam y2r_pkg::in_t  NO_PX   = 24'h0;
  localparam y2r_pkg::out_t NO_WANT = 18'h0;

  localparam script_row_t DIRECTED [25] = '{
    // reset sizes: the first source pixel lies off the output grid
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'h808080, 1'b0, NO_WANT},
    // 2x2 onto 2x2: every source pixel is picked
    '{ROW_WRITE, y2r_pkg::REG_SRC_WIDTH,  12'd2,    NO_PX,      1'b0, NO_WANT},
    '{ROW_WRITE, y2r_pkg::REG_SRC_HEIGHT, 12'd2,    NO_PX,      1'b0, NO_WANT},
    '{ROW_WRITE, y2r_pkg::REG_OUT_WIDTH,  12'd2,    NO_PX,      1'b0, NO_WANT},
    '{ROW_WRITE, y2r_pkg::REG_OUT_HEIGHT, 12'd2,    NO_PX,      1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH, 12'd0, 24'hFF8080, 1'b1, {16'hFFFF, 1'b0, 1'b0}},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH, 12'd0, 24'h008080, 1'b1, {16'h0000, 1'b1, 1'b0}},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'h000000, 1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'hFFFFFF, 1'b0, NO_WANT},
    // next frame starts on its own after the last pixel
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'h00FF00, 1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'hFF00FF, 1'b0, NO_WANT},
    // zero width counts as one; output width 2 then clips to 1
    '{ROW_WRITE, y2r_pkg::REG_SRC_WIDTH,  12'd0,    NO_PX,      1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'h102030, 1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'h807F81, 1'b0, NO_WANT},
    // oversized source width clips to the maximum
    '{ROW_WRITE, y2r_pkg::REG_SRC_WIDTH,  12'd4095, NO_PX,      1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'h55AA55, 1'b0, NO_WANT},
    // zero output width: nothing is ever picked
    '{ROW_WRITE, y2r_pkg::REG_OUT_WIDTH,  12'd0,    NO_PX,      1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'hAA55AA, 1'b0, NO_WANT},
    // 4 columns onto 3
    '{ROW_WRITE, y2r_pkg::REG_SRC_WIDTH,  12'd4,    NO_PX,      1'b0, NO_WANT},
    '{ROW_WRITE, y2r_pkg::REG_OUT_WIDTH,  12'd3,    NO_PX,      1'b0, NO_WANT},
    '{ROW_WRITE, y2r_pkg::REG_OUT_HEIGHT, 12'd2,    NO_PX,      1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'h3C6E91, 1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'hC81E64, 1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'h7FC0F0, 1'b0, NO_WANT},
    '{ROW_PIXEL, y2r_pkg::REG_SRC_WIDTH,  12'd0,    24'hE0100A, 1'b0, NO_WANT}
  };

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  y2r_pkg::in_t      source;
  logic              empty;
  logic              pop;
  y2r_pkg::out_t     result;
  logic              cfg_valid;
  logic              cfg_ready;
  y2r_pkg::cfg_idx_t cfg_index;
  logic [11:0]       cfg_data;

  yuv420_to_rgb565_scaler DUT (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .source    (source),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register mirror and scan position of the frame being received.
  logic [11:0] reg_file [4];
  int          src_col, src_row, dst_col, dst_row;
  int          col_acc, row_acc;

  y2r_pkg::out_t expected_pixels [$];
  y2r_pkg::out_t want_px;
  int            error_count;
  int            idle_cycles;
  int            tx_idle_pct;
  int            rx_idle_pct;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clip_source(logic [11:0] v, int lim);
    if (v == 0) return 1;
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic logic [7:0] clamp_channel(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Full-range BT.601, floor shifts, RGB565 with the bytes swapped.
  function automatic logic [15:0] bt601_to_rgb565_be(y2r_pkg::in_t px);
    int          y, u, v;
    logic [7:0]  r, g, b;
    logic [15:0] pk;
    y  = int'(px.luma);
    u  = int'(px.chroma_blue) - 128;
    v  = int'(px.chroma_red) - 128;
    r  = clamp_channel(y + ((359 * v) >>> 8));
    g  = clamp_channel(y - ((88 * u + 183 * v) >>> 8));
    b  = clamp_channel(y + ((454 * u) >>> 8));
    pk = {r[7:3], g[7:2], b[7:3]};
    return {pk[7:0], pk[15:8]};
  endfunction

  function automatic void rewind_frame();
    src_col = 0;
    src_row = 0;
    dst_col = 0;
    dst_row = 0;
    col_acc = clip_source(reg_file[y2r_pkg::REG_SRC_WIDTH], MAX_W) / 2;
    row_acc = clip_source(reg_file[y2r_pkg::REG_SRC_HEIGHT], MAX_H) / 2;
  endfunction

  // Advance the scan by one source pixel; return 1 with res filled when the
  // pixel lands on the output grid.
  function automatic bit advance_scaler(y2r_pkg::in_t px, output y2r_pkg::out_t res);
    int sw, sh, ow, oh;
    bit row_pick, col_pick, hit;
    sw = clip_source(reg_file[y2r_pkg::REG_SRC_WIDTH], MAX_W);
    sh = clip_source(reg_file[y2r_pkg::REG_SRC_HEIGHT], MAX_H);
    ow = int'(reg_file[y2r_pkg::REG_OUT_WIDTH]);
    if (ow > sw) ow = sw;
    oh = int'(reg_file[y2r_pkg::REG_OUT_HEIGHT]);
    if (oh > sh) oh = sh;
    row_pick = (row_acc < oh) && (dst_row < oh);
    col_pick = (col_acc < ow) && (dst_col < ow);
    hit = row_pick && col_pick;
    res = '0;
    if (hit) begin
      res.pixel_be  = bt601_to_rgb565_be(px);
      res.row_end   = (dst_col + 1) == ow;
      res.frame_end = res.row_end && ((dst_row + 1) == oh);
    end
    if (col_pick) begin
      dst_col++;
      col_acc += sw;
    end
    col_acc -= ow;
    src_col++;
    if (src_col >= sw) begin
      src_col = 0;
      dst_col = 0;
      col_acc = sw / 2;
      if (row_pick) begin
        dst_row++;
        row_acc += sh;
      end
      row_acc -= oh;
      src_row++;
      if (src_row >= sh) rewind_frame();
    end
    return hit;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Hold the register write until the block takes it, then track it in the
  // mirror; every write restarts the frame.
  task automatic write_reg(y2r_pkg::cfg_idx_t idx, logic [11:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    reg_file[idx] = value;
    rewind_frame();
  endtask

  // Idle the sender at random, then present the pixel until it transfers.
  // A typed row overrides the predicted result with the hand-written one.
  task automatic send_pixel(y2r_pkg::in_t px, bit typed, y2r_pkg::out_t typed_want);
    y2r_pkg::out_t res;
    bit            hit;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    source <= px;
    do @(posedge clk); while (full);
    hit = advance_scaler(px, res);
    if (hit) expected_pixels.push_back(typed ? typed_want : res);
  endtask

  // Stop sending, drain every outstanding result, then let the pipeline settle.
  task automatic wait_for_results();
    push <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: stall at random according to the current pace.
  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Compare each popped result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with nothing expected", result, 0);
      end else begin
        want_px = expected_pixels.pop_front();
        if (result.pixel_be !== want_px.pixel_be)
          report_mismatch("pixel_be", result.pixel_be, want_px.pixel_be);
        if (result.row_end !== want_px.row_end)
          report_mismatch("row_end", result.row_end, want_px.row_end);
        if (result.frame_end !== want_px.frame_end)
          report_mismatch("frame_end", result.frame_end, want_px.frame_end);
      end
    end
  end

  // Hang detection: any transfer on any channel resets the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int sw, sh, ow, oh, burst, items_sent;
    rst         <= 1'b1;
    push        <= 1'b0;
    source      <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= y2r_pkg::REG_SRC_WIDTH;
    cfg_data    <= '0;
    rx_idle_pct <= 72;
    tx_idle_pct = 22;
    error_count = 0;
    items_sent  = 0;
    reg_file[y2r_pkg::REG_SRC_WIDTH]  = y2r_pkg::SRC_WIDTH_RST;
    reg_file[y2r_pkg::REG_SRC_HEIGHT] = y2r_pkg::SRC_HEIGHT_RST;
    reg_file[y2r_pkg::REG_OUT_WIDTH]  = y2r_pkg::OUT_WIDTH_RST;
    reg_file[y2r_pkg::REG_OUT_HEIGHT] = y2r_pkg::OUT_HEIGHT_RST;
    rewind_frame();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed script; drain before each run of register writes.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        if (i > 0 && DIRECTED[i - 1].kind == ROW_PIXEL) wait_for_results();
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        cfg_valid <= 1'b0;
        send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end

    // Random frames: mostly small well-formed downscales, run for whole frames up
    // to the burst cap, with clipped, degenerate and full-range settings mixed in.
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent < RANDOM_ITEMS / 3) begin
        tx_idle_pct = 22;
        rx_idle_pct <= 72;
      end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 72;
        rx_idle_pct <= 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      wait_for_results();

      sw    = 2 * $urandom_range(1, 8);
      sh    = 2 * $urandom_range(1, 5);
      ow    = $urandom_range(1, sw);
      oh    = $urandom_range(1, sh);
      burst = sw * sh * $urandom_range(1, 3);
      case ($urandom_range(0, 9))
        0: begin
          // any 12-bit value, zero and oversized included
          sw    = $urandom_range(0, 4095);
          sh    = $urandom_range(0, 4095);
          ow    = $urandom_range(0, 4095);
          oh    = $urandom_range(0, 4095);
          burst = 40;
        end
        1: begin
          if ($urandom_range(0, 1)) ow = 0;
          else oh = 0;
          burst = 24;
        end
        2: begin
          // ask for more columns than the source has and at least as many rows
          ow    = sw + $urandom_range(1, 8);
          oh    = sh + $urandom_range(0, 4);
          burst = sw * sh * 2;
        end
        3: begin
          sw    = MAX_W;
          ow    = $urandom_range(1, MAX_W);
          burst = 60;
        end
        default: ;
      endcase
      if (burst > 120) burst = 120;

      write_reg(y2r_pkg::REG_SRC_WIDTH,  12'(sw));
      write_reg(y2r_pkg::REG_SRC_HEIGHT, 12'(sh));
      write_reg(y2r_pkg::REG_OUT_WIDTH,  12'(ow));
      write_reg(y2r_pkg::REG_OUT_HEIGHT, 12'(oh));
      cfg_valid <= 1'b0;

      repeat (burst) begin
        // now and then hold the sender until the block has caught up
        if ($urandom_range(0, 63) == 0) wait_for_results();
        send_pixel(y2r_pkg::in_t'(24'($urandom)), 1'b0, NO_WANT);
        items_sent++;
      end
    end

    wait_for_results();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
